// ===== rtl/uvs_pkg.sv =====
// Shared types, constants and helper functions of the UV sphere vertex generator.
// No dependencies; imported by the divider cell, the CORDIC cell and the top level.
package uvs_pkg;

	// Angle quotient width: angles up to two pi in unsigned Q3.30.
	localparam int QW = 33;

	localparam logic [32:0] PI_Q30         = 33'd3373259426;
	localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
	localparam logic [32:0] HALF_PI_Q30    = 33'd1686629713;
	localparam logic [32:0] THREE_HALF_Q30 = 33'd5059889139;
	localparam logic [31:0] CORDIC_K_Q30   = 32'd652032874;

	// Configuration register indexes.
	localparam logic [1:0] REG_RADIUS   = 2'd0;
	localparam logic [1:0] REG_LONG_SEG = 2'd1;
	localparam logic [1:0] REG_LAT_SEG  = 2'd2;

	// Corner indices and triangle flags that travel beside the angle data.
	typedef struct packed {
		logic [16:0] corner_a;
		logic [16:0] corner_b;
		logic [16:0] corner_c;
		logic [16:0] corner_d;
		logic        upper;
		logic        lower;
	} side_t;

	// One rotation in flight: vector, residual angle and quadrant fold flag.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               neg;
	} rot_t;

	// Arctangent of 2^-i in Q30.
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		begin
			case (i)
				0: r = 32'd843314857;
				1: r = 32'd497837829;
				2: r = 32'd263043837;
				3: r = 32'd133525159;
				4: r = 32'd67021687;
				5: r = 32'd33543516;
				6: r = 32'd16775851;
				7: r = 32'd8388437;
				8: r = 32'd4194283;
				9: r = 32'd2097149;
				10: r = 32'd1048576;
				11: r = 32'd524288;
				12: r = 32'd262144;
				13: r = 32'd131072;
				14: r = 32'd65536;
				15: r = 32'd32768;
				16: r = 32'd16384;
				17: r = 32'd8192;
				18: r = 32'd4096;
				19: r = 32'd2048;
				20: r = 32'd1024;
				21: r = 32'd512;
				22: r = 32'd256;
				23: r = 32'd128;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

	// Fold an angle in [0, 2pi] into [-pi/2, pi/2] and load the CORDIC start vector.
	function automatic rot_t rot_init(input logic [32:0] a);
		rot_t        r;
		logic [33:0] z;
		begin
			r.x   = CORDIC_K_Q30;
			r.y   = '0;
			r.neg = 1'b0;
			if (a <= HALF_PI_Q30) begin
				z = {1'b0, a};
			end else if (a < THREE_HALF_Q30) begin
				z     = {1'b0, a} - {1'b0, PI_Q30};
				r.neg = 1'b1;
			end else begin
				z = {1'b0, a} - {1'b0, TWO_PI_Q30};
			end
			r.z = z[31:0];
			return r;
		end
	endfunction

	// Clamp a normal component to plus or minus one in Q1.14.
	function automatic logic signed [15:0] clamp_unit(input logic signed [19:0] v);
		logic signed [15:0] r;
		begin
			if (v > 20'sd16384) begin
				r = 16'sd16384;
			end else if (v < -20'sd16384) begin
				r = -16'sd16384;
			end else begin
				r = v[15:0];
			end
			return r;
		end
	endfunction

endpackage

// ===== rtl/uv_sphere_vertex_index_generator.sv =====
// Top level of the UV sphere vertex generator: front stage, cell chains and output stages.
// Depends on uvs_pkg, uvs_div_cell and uvs_cordic_cell.
//
// Use: write sphere_radius, long_segments and lat_segments through cfg_we, cfg_index and
// cfg_data while no request is in flight. Each request on the slave stream carries one
// grid point (latitude row, longitude column); each request on the master stream carries
// the matching vertex position, unit normal, the four corner indices of the cell that
// starts there, and the two triangle flags in m_tuser.
// From acceptance to m_tvalid a point passes one front stage, 33 divide cells (one
// quotient bit each), CORDIC_STAGES rotation cells and four output stages for the
// products, normals, radius scaling and rounding. Throughput is one point per cycle
// while the receiver keeps up; every stage holds its own valid bit, so bubbles close up
// and a new point is taken while a finished result waits. When the receiver stalls,
// requests stack up in the chain until it is full, after which s_tready falls. Reset
// empties the chain and loads radius 1.0 and 16 by 16 segments.
module uv_sphere_vertex_index_generator #(
	parameter int MAX_SEGMENTS  = 256,
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // lat_index[8:0], long_index[17:9], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, corner_a, corner_b, corner_c, corner_d, pad
	output logic [167:0] m_tdata,
	output logic [1:0]   m_tuser    // upper_tri_ok, lower_tri_ok
);
	import uvs_pkg::*;

	localparam int DW = $clog2(MAX_SEGMENTS + 1);
	localparam int NW = DW + QW;
	localparam int CW = (2 * DW + 2 > 17) ? 2 * DW + 2 : 17;
	localparam int NC = CORDIC_STAGES;

	// Configuration registers.
	logic [15:0] radius_q;
	logic [8:0]  long_seg_q, lat_seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= 16'd256;
			long_seg_q <= 9'd16;
			lat_seg_q  <= 9'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS:   radius_q   <= cfg_data;
				REG_LONG_SEG: long_seg_q <= cfg_data[8:0];
				REG_LAT_SEG:  lat_seg_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Effective segment counts and clamped indices.
	logic [DW-1:0] seg_l, seg_s, lat_c, lon_c;
	logic [8:0]    in_lat, in_lon;

	assign in_lat = s_tdata[8:0];
	assign in_lon = s_tdata[17:9];

	always_comb begin
		if (long_seg_q < 9'd3) begin
			seg_l = DW'(3);
		end else if (32'(long_seg_q) > MAX_SEGMENTS) begin
			seg_l = DW'(MAX_SEGMENTS);
		end else begin
			seg_l = DW'(long_seg_q);
		end
		if (lat_seg_q < 9'd2) begin
			seg_s = DW'(2);
		end else if (32'(lat_seg_q) > MAX_SEGMENTS) begin
			seg_s = DW'(MAX_SEGMENTS);
		end else begin
			seg_s = DW'(lat_seg_q);
		end
		lat_c = (32'(in_lat) > 32'(seg_s)) ? seg_s : DW'(in_lat);
		lon_c = (32'(in_lon) > 32'(seg_l)) ? seg_l : DW'(in_lon);
	end

	// Angle numerators with rounding, and the corner indices of the cell.
	logic [NW-1:0] num_t, num_p;
	logic [CW-1:0] idx_a, idx_b, stride;
	side_t         side_d;
	logic          pt_ok;

	always_comb begin
		num_t  = NW'(lat_c) * NW'(PI_Q30) + NW'(seg_s >> 1);
		num_p  = NW'(lon_c) * NW'(TWO_PI_Q30) + NW'(seg_l >> 1);
		stride = CW'(seg_l) + CW'(1);
		idx_a  = CW'(lat_c) * stride + CW'(lon_c);
		idx_b  = idx_a + stride;
		pt_ok  = (lat_c < seg_s) && (lon_c < seg_l);
		side_d.corner_a = idx_a[16:0];
		side_d.corner_b = idx_b[16:0];
		side_d.corner_c = idx_a[16:0] + 17'd1;
		side_d.corner_d = idx_b[16:0] + 17'd1;
		side_d.upper    = pt_ok && (lat_c != '0);
		side_d.lower    = pt_ok && (lat_c != seg_s - DW'(1));
	end

	// Front stage.
	logic          v_s1;
	logic [DW-1:0] rem_t_s1, rem_p_s1;
	logic [QW-1:0] nq_t_s1, nq_p_s1;
	side_t         side_s1;

	logic          dv [0:QW];
	logic          dr [0:QW];
	logic [DW-1:0] drt [0:QW];
	logic [DW-1:0] drp [0:QW];
	logic [QW-1:0] dqt [0:QW];
	logic [QW-1:0] dqp [0:QW];
	side_t         dsd [0:QW];

	assign s_tready = !v_s1 || dr[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rem_t_s1 <= num_t[NW-1:QW];
			nq_t_s1  <= num_t[QW-1:0];
			rem_p_s1 <= num_p[NW-1:QW];
			nq_p_s1  <= num_p[QW-1:0];
			side_s1  <= side_d;
		end
	end

	// Divider chain: one quotient bit per cell.
	assign dv[0]  = v_s1;
	assign drt[0] = rem_t_s1;
	assign drp[0] = rem_p_s1;
	assign dqt[0] = nq_t_s1;
	assign dqp[0] = nq_p_s1;
	assign dsd[0] = side_s1;

	for (genvar i = 0; i < QW; i++) begin : g_div
		uvs_div_cell #(.DW(DW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.seg_t     (seg_s),
			.seg_p     (seg_l),
			.in_valid  (dv[i]),
			.in_ready  (dr[i]),
			.in_rem_t  (drt[i]),
			.in_nq_t   (dqt[i]),
			.in_rem_p  (drp[i]),
			.in_nq_p   (dqp[i]),
			.in_side   (dsd[i]),
			.out_valid (dv[i+1]),
			.out_ready (dr[i+1]),
			.out_rem_t (drt[i+1]),
			.out_nq_t  (dqt[i+1]),
			.out_rem_p (drp[i+1]),
			.out_nq_p  (dqp[i+1]),
			.out_side  (dsd[i+1])
		);
	end

	// CORDIC chain: one micro-rotation per cell, after the quadrant fold.
	logic  cv [0:NC];
	logic  cr [0:NC];
	rot_t  cth [0:NC];
	rot_t  cph [0:NC];
	side_t csd [0:NC];

	assign cv[0]  = dv[QW];
	assign dr[QW] = cr[0];
	assign cth[0] = rot_init(dqt[QW]);
	assign cph[0] = rot_init(dqp[QW]);
	assign csd[0] = dsd[QW];

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		uvs_cordic_cell #(.STAGE(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (cr[i]),
			.in_th     (cth[i]),
			.in_ph     (cph[i]),
			.in_side   (csd[i]),
			.out_valid (cv[i+1]),
			.out_ready (cr[i+1]),
			.out_th    (cth[i+1]),
			.out_ph    (cph[i+1]),
			.out_side  (csd[i+1])
		);
	end

	// Output stages with their ready chain.
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic v_s2, v_s3, v_s4, v_s5;

	assign rdy_s5 = !v_s5 || m_tready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign cr[NC] = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= cv[NC];
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Sine and cosine with the quadrant fold undone.
	logic signed [31:0] st, ct, sp, cp;

	always_comb begin
		rot_t th, ph;
		th = cth[NC];
		ph = cph[NC];
		st = th.neg ? -$signed(th.y) : $signed(th.y);
		ct = th.neg ? -$signed(th.x) : $signed(th.x);
		sp = ph.neg ? -$signed(ph.y) : $signed(ph.y);
		cp = ph.neg ? -$signed(ph.x) : $signed(ph.x);
	end

	// Stage 2: products of the azimuth and polar terms.
	logic signed [63:0] px_s2, pz_s2;
	logic signed [31:0] ct_s2;
	side_t              side_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && cv[NC]) begin
			px_s2   <= cp * st;
			pz_s2   <= sp * st;
			ct_s2   <= ct;
			side_s2 <= csd[NC];
		end
	end

	// Stage 3: round and clamp the normal.
	logic signed [64:0] rx, rz;
	logic signed [32:0] ry;
	logic signed [15:0] nx_s3, ny_s3, nz_s3;
	side_t              side_s3;

	always_comb begin
		rx = $signed({px_s2[63], px_s2}) + (65'sd1 <<< 45);
		rz = $signed({pz_s2[63], pz_s2}) + (65'sd1 <<< 45);
		ry = $signed({ct_s2[31], ct_s2}) + 33'sd32768;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			nx_s3   <= clamp_unit($signed({rx[64], rx[64:46]}));
			ny_s3   <= clamp_unit($signed({{3{ry[32]}}, ry[32:16]}));
			nz_s3   <= clamp_unit($signed({rz[64], rz[64:46]}));
			side_s3 <= side_s2;
		end
	end

	// Stage 4: scale by the radius.
	logic signed [32:0] qx_s4, qy_s4, qz_s4;
	logic signed [15:0] nx_s4, ny_s4, nz_s4;
	side_t              side_s4;
	logic signed [16:0] rad;

	assign rad = $signed({1'b0, radius_q});

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			qx_s4   <= rad * nx_s3;
			qy_s4   <= rad * ny_s3;
			qz_s4   <= rad * nz_s3;
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			nz_s4   <= nz_s3;
			side_s4 <= side_s3;
		end
	end

	// Stage 5: round the position to Q8.8; this is the output register.
	logic signed [33:0] ox, oy, oz;
	logic [16:0]        pos_x_s5, pos_y_s5, pos_z_s5;
	logic [15:0]        nx_s5, ny_s5, nz_s5;
	side_t              side_s5;

	always_comb begin
		ox = $signed({qx_s4[32], qx_s4}) + 34'sd8192;
		oy = $signed({qy_s4[32], qy_s4}) + 34'sd8192;
		oz = $signed({qz_s4[32], qz_s4}) + 34'sd8192;
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			pos_x_s5 <= ox[30:14];
			pos_y_s5 <= oy[30:14];
			pos_z_s5 <= oz[30:14];
			nx_s5    <= nx_s4;
			ny_s5    <= ny_s4;
			nz_s5    <= nz_s4;
			side_s5  <= side_s4;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {1'b0, side_s5.corner_d, side_s5.corner_c, side_s5.corner_b,
		side_s5.corner_a, nz_s5, ny_s5, nx_s5, pos_z_s5, pos_y_s5, pos_x_s5};
	assign m_tuser  = {side_s5.lower, side_s5.upper};

`ifndef SYNTHESIS
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted request did not reach the front stage");
	a_nrm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(nx_s5) <= 16'sd16384 && $signed(nx_s5) >= -16'sd16384 &&
			$signed(ny_s5) <= 16'sd16384 && $signed(ny_s5) >= -16'sd16384))
		else $error("normal component out of unit range");
	a_corner_rel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (side_s5.corner_c == side_s5.corner_a + 17'd1 &&
			side_s5.corner_d == side_s5.corner_b + 17'd1))
		else $error("corner indices inconsistent");
	a_flag_cols: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> side_s5.corner_a != 17'd0 || side_s5.corner_b != 17'd0)
		else $error("upper triangle flagged on a cell with degenerate corners");
`endif

endmodule

// ===== rtl/uvs_div_cell.sv =====
// One restoring divide step for the polar and azimuth angles, with its own request register.
// Depends on uvs_pkg for the quotient width and the side-band type.
module uvs_div_cell #(
	parameter int DW = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DW-1:0]        seg_t,
	input  logic [DW-1:0]        seg_p,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DW-1:0]        in_rem_t,
	input  logic [uvs_pkg::QW-1:0] in_nq_t,
	input  logic [DW-1:0]        in_rem_p,
	input  logic [uvs_pkg::QW-1:0] in_nq_p,
	input  uvs_pkg::side_t       in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DW-1:0]        out_rem_t,
	output logic [uvs_pkg::QW-1:0] out_nq_t,
	output logic [DW-1:0]        out_rem_p,
	output logic [uvs_pkg::QW-1:0] out_nq_p,
	output uvs_pkg::side_t       out_side
);
	import uvs_pkg::*;

	logic          valid_q;
	logic [DW:0]   sh_t, sh_p;
	logic          ge_t, ge_p;
	logic [DW:0]   dif_t, dif_p;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Shift in the next numerator bit and subtract the divisor where it fits.
	always_comb begin
		sh_t  = {in_rem_t, in_nq_t[QW-1]};
		sh_p  = {in_rem_p, in_nq_p[QW-1]};
		ge_t  = sh_t >= {1'b0, seg_t};
		ge_p  = sh_p >= {1'b0, seg_p};
		dif_t = ge_t ? sh_t - {1'b0, seg_t} : sh_t;
		dif_p = ge_p ? sh_p - {1'b0, seg_p} : sh_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_rem_t <= dif_t[DW-1:0];
			out_rem_p <= dif_p[DW-1:0];
			out_nq_t  <= {in_nq_t[QW-2:0], ge_t};
			out_nq_p  <= {in_nq_p[QW-2:0], ge_p};
			out_side  <= in_side;
		end
	end

endmodule

// ===== rtl/uvs_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation for both angles, with its own request register.
// Depends on uvs_pkg for the rotation type and the arctangent table.
module uvs_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  uvs_pkg::rot_t  in_th,
	input  uvs_pkg::rot_t  in_ph,
	input  uvs_pkg::side_t in_side,
	output logic           out_valid,
	input  logic           out_ready,
	output uvs_pkg::rot_t  out_th,
	output uvs_pkg::rot_t  out_ph,
	output uvs_pkg::side_t out_side
);
	import uvs_pkg::*;

	localparam logic signed [31:0] ATAN = $signed(atan_q30(STAGE));

	logic  valid_q;
	rot_t  nx_th, nx_ph;

	function automatic rot_t step(input rot_t r);
		rot_t               o;
		logic signed [31:0] dx, dy;
		begin
			dx = $signed(r.y) >>> STAGE;
			dy = $signed(r.x) >>> STAGE;
			o.neg = r.neg;
			if (!r.z[31]) begin
				o.x = $signed(r.x) - dx;
				o.y = $signed(r.y) + dy;
				o.z = $signed(r.z) - ATAN;
			end else begin
				o.x = $signed(r.x) + dx;
				o.y = $signed(r.y) - dy;
				o.z = $signed(r.z) + ATAN;
			end
			return o;
		end
	endfunction

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Rotate both vectors towards their residual angles.
	always_comb begin
		nx_th = step(in_th);
		nx_ph = step(in_ph);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_th   <= nx_th;
			out_ph   <= nx_ph;
			out_side <= in_side;
		end
	end

endmodule

// ===== verif/uv_sphere_vertex_index_generator_test.sv =====
// Self-checking testbench of the UV sphere vertex and index generator.
// Depends on uvs_pkg and the top level uv_sphere_vertex_index_generator; needs no files.
// Directed points and random points under several register settings are checked result by result.
module uv_sphere_vertex_index_generator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import uvs_pkg::*;

	localparam int     SEG_MAX     = 256;
	localparam int     ROT_STAGES  = 16;
	localparam longint PI_FIX      = 64'sd3373259426;
	localparam longint HALF_PI_FIX = 64'sd1686629713;
	localparam longint GAIN_FIX    = 64'sd652032874;

	// Arctangent of 2^-i in Q30 radians.
	localparam longint ATAN_FIX [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
		8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128};

	// One vertex with its cell indices and triangle flags.
	typedef struct {
		logic signed [16:0] pos_x, pos_y, pos_z;
		logic signed [15:0] nrm_x, nrm_y, nrm_z;
		logic [16:0]        corner_a, corner_b, corner_c, corner_d;
		logic               upper_ok, lower_ok;
	} vertex_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [23:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [167:0] m_tdata;
	logic [1:0]   m_tuser;

	// Register copies held by the testbench.
	logic [15:0] radius_q;
	logic [8:0]  long_seg_q;
	logic [8:0]  lat_seg_q;

	vertex_t vertices_due[$];
	int      mismatches;
	bit      calm;

	uv_sphere_vertex_index_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock: 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Effective segment counts after clamping.
	function automatic int long_count();
		int v;
		begin
			v = long_seg_q;
			return (v < 3) ? 3 : (v > SEG_MAX) ? SEG_MAX : v;
		end
	endfunction

	function automatic int lat_count();
		int v;
		begin
			v = lat_seg_q;
			return (v < 2) ? 2 : (v > SEG_MAX) ? SEG_MAX : v;
		end
	endfunction

	// Rotation sine and cosine of an angle in [0, 2pi], Q30.
	task automatic rotate(input longint ang, output longint sn, output longint cs);
		longint x, y, z, dx, dy;
		bit     flip;
		begin
			x = GAIN_FIX;
			y = 0;
			flip = 1'b0;
			if (ang <= HALF_PI_FIX) begin
				z = ang;
			end else if (ang < PI_FIX + HALF_PI_FIX) begin
				z = ang - PI_FIX;
				flip = 1'b1;
			end else begin
				z = ang - 2 * PI_FIX;
			end
			for (int i = 0; i < ROT_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_FIX[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_FIX[i];
				end
			end
			sn = flip ? -y : y;
			cs = flip ? -x : x;
		end
	endtask

	function automatic longint unit_clamp(input longint v);
		return (v > 16384) ? 64'sd16384 : (v < -16384) ? -64'sd16384 : v;
	endfunction

	function automatic longint scale_radius(input longint n);
		return ((longint'(radius_q) * n) + 8192) >>> 14;
	endfunction

	// Works out the vertex expected for one grid point under the current registers.
	task automatic predict_vertex(input int lat_in, input int long_in, output vertex_t v);
		int     ls, ts, lat, lon;
		longint theta, phi, st, ct, sp, cp, nx, ny, nz, stride, a, b;
		bit     inside_grid;
		begin
			ls = long_count();
			ts = lat_count();
			lat = (lat_in > ts) ? ts : lat_in;
			lon = (long_in > ls) ? ls : long_in;
			theta = (longint'(lat) * PI_FIX + ts / 2) / ts;
			phi = (longint'(lon) * 2 * PI_FIX + ls / 2) / ls;
			rotate(theta, st, ct);
			rotate(phi, sp, cp);
			nx = unit_clamp((cp * st + (64'sd1 <<< 45)) >>> 46);
			ny = unit_clamp((ct + (64'sd1 <<< 15)) >>> 16);
			nz = unit_clamp((sp * st + (64'sd1 <<< 45)) >>> 46);
			v.pos_x = 17'(scale_radius(nx));
			v.pos_y = 17'(scale_radius(ny));
			v.pos_z = 17'(scale_radius(nz));
			v.nrm_x = 16'(nx);
			v.nrm_y = 16'(ny);
			v.nrm_z = 16'(nz);
			stride = ls + 1;
			a = lat * stride + lon;
			b = a + stride;
			v.corner_a = 17'(a);
			v.corner_b = 17'(b);
			v.corner_c = 17'(a + 1);
			v.corner_d = 17'(b + 1);
			inside_grid = (lat < ts) && (lon < ls);
			v.upper_ok = inside_grid && (lat != 0);
			v.lower_ok = inside_grid && (lat != ts - 1);
		end
	endtask

	task automatic report(input string field, input longint got, input longint want);
		begin
			mismatches++;
			$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
		end
	endtask

	// Sends one grid point, after a random gap unless calm is set, and books its expected vertex on acceptance.
	task automatic send_point(input int lat, input int lon);
		int      gap;
		vertex_t v;
		begin
			gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
			repeat (gap) begin
				@(negedge clk);
				s_tvalid = 1'b0;
			end
			@(negedge clk);
			s_tdata = {6'd0, 9'(lon), 9'(lat)};
			s_tvalid = 1'b1;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			predict_vertex(lat, lon, v);
			vertices_due.push_back(v);
		end
	endtask

	// Lowers the request and waits for the chain to drain.
	task automatic drain();
		begin
			@(negedge clk);
			s_tvalid = 1'b0;
			while (vertices_due.size() != 0)
				@(posedge clk);
			repeat (70) @(posedge clk);
		end
	endtask

	// Register write while idle; the copy follows the masking of the port.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_index = idx;
			cfg_data = value;
			@(negedge clk);
			cfg_we = 1'b0;
			case (idx)
				REG_RADIUS:   radius_q = value;
				REG_LONG_SEG: long_seg_q = value[8:0];
				REG_LAT_SEG:  lat_seg_q = value[8:0];
				default: ;
			endcase
		end
	endtask

	task automatic set_regs(input logic [15:0] r, input logic [15:0] ls, input logic [15:0] ts);
		begin
			drain();
			write_reg(REG_RADIUS, r);
			write_reg(REG_LONG_SEG, ls);
			write_reg(REG_LAT_SEG, ts);
		end
	endtask

	// Poles, seam, last row and column, and indices past the grid at reset settings.
	task automatic test_grid_edges();
		begin
			send_point(0, 0);
			send_point(1, 0);
			send_point(8, 4);
			send_point(15, 15);
			send_point(16, 0);
			send_point(16, 16);
			send_point(0, 16);
			send_point(511, 511);
			send_point(300, 3);
			send_point(4, 257);
		end
	endtask

	// Segment registers below and above their ranges, and bits beyond nine.
	task automatic test_segment_clamp();
		begin
			set_regs(16'hFFFF, 16'd0, 16'd0);
			send_point(0, 0);
			send_point(1, 2);
			send_point(2, 3);
			send_point(511, 511);
			set_regs(16'd0, 16'h01FF, 16'hFE01);
			send_point(255, 255);
			send_point(256, 256);
			send_point(0, 128);
		end
	endtask

	// A write to the unused register index changes nothing.
	task automatic test_unused_index();
		begin
			set_regs(16'd256, 16'd16, 16'd16);
			write_reg(2'd3, 16'd5);
			send_point(3, 5);
			send_point(16, 16);
		end
	endtask

	// Random points under one setting: mostly inside the grid, some anywhere.
	task automatic test_random_points(input logic [15:0] r, input logic [15:0] ls,
			input logic [15:0] ts, input int count);
		int lat, lon;
		begin
			set_regs(r, ls, ts);
			repeat (count) begin
				if ($urandom_range(0, 9) < 8) begin
					lat = $urandom_range(0, lat_count());
					lon = $urandom_range(0, long_count());
				end else begin
					lat = $urandom_range(0, 511);
					lon = $urandom_range(0, 511);
				end
				send_point(lat, lon);
			end
		end
	endtask

	// Receiver stalls in random bursts.
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready = 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 12);
			m_tready = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	// Compares each accepted result with the oldest expected vertex.
	always @(posedge clk) begin
		vertex_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (vertices_due.size() == 0) begin
				report("requests waiting", 0, 1);
			end else begin
				w = vertices_due.pop_front();
				if (m_tdata[16:0] !== w.pos_x) report("pos_x", $signed(m_tdata[16:0]), w.pos_x);
				if (m_tdata[33:17] !== w.pos_y) report("pos_y", $signed(m_tdata[33:17]), w.pos_y);
				if (m_tdata[50:34] !== w.pos_z) report("pos_z", $signed(m_tdata[50:34]), w.pos_z);
				if (m_tdata[66:51] !== w.nrm_x) report("nrm_x", $signed(m_tdata[66:51]), w.nrm_x);
				if (m_tdata[82:67] !== w.nrm_y) report("nrm_y", $signed(m_tdata[82:67]), w.nrm_y);
				if (m_tdata[98:83] !== w.nrm_z) report("nrm_z", $signed(m_tdata[98:83]), w.nrm_z);
				if (m_tdata[115:99] !== w.corner_a)
					report("corner_a", m_tdata[115:99], w.corner_a);
				if (m_tdata[132:116] !== w.corner_b)
					report("corner_b", m_tdata[132:116], w.corner_b);
				if (m_tdata[149:133] !== w.corner_c)
					report("corner_c", m_tdata[149:133], w.corner_c);
				if (m_tdata[166:150] !== w.corner_d)
					report("corner_d", m_tdata[166:150], w.corner_d);
				if (m_tuser[0] !== w.upper_ok) report("upper_tri_ok", m_tuser[0], w.upper_ok);
				if (m_tuser[1] !== w.lower_ok) report("lower_tri_ok", m_tuser[1], w.lower_ok);
			end
		end
	end

	// Watchdog for a hung handshake.
	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Test sequence.
	initial begin
		mismatches = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		radius_q = 16'd256;
		long_seg_q = 9'd16;
		lat_seg_q = 9'd16;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_grid_edges();
		test_segment_clamp();
		test_unused_index();
		test_random_points(16'd256, 16'd16, 16'd16, 200);
		test_random_points(16'hFFFF, 16'd256, 16'd256, 200);
		test_random_points(16'd0, 16'd3, 16'd2, 150);
		test_random_points(16'($urandom), 16'($urandom_range(0, 511)),
			16'($urandom_range(0, 511)), 200);
		test_random_points(16'($urandom), 16'($urandom_range(3, 40)),
			16'($urandom_range(2, 40)), 150);
		calm = 1'b1;
		test_random_points(16'd1000, 16'd24, 16'd12, 150);
		drain();

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
